@@ src/dft_pkg.sv @@
// Package for the delimited field tokenizer: character codes, register
// indexes, the character class bundle and the per-character result record.
// No dependencies.
`timescale 1ns / 1ps

package dft_pkg;

    // Default longest line, in characters
    localparam int MAX_LINE_DEF = 256;

    // Configuration register indexes
    localparam logic [1:0] REG_SEPARATOR   = 2'd0;
    localparam logic [1:0] REG_NUMBER_BASE = 2'd1;
    localparam logic [1:0] REG_ALLOW_EMPTY = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0] SEPARATOR_RST   = 8'd44;
    localparam logic [4:0] NUMBER_BASE_RST = 5'd10;

    // Character codes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;

    // What one character is, as seen by the line state machine
    typedef struct packed {
        logic       is_sep;
        logic       is_quote;
        logic       is_space;
        logic       is_hex;
        logic [3:0] digit;
    } char_class_t;

    // One result item
    typedef struct packed {
        logic        line_end;
        logic        parse_error;
        logic        value_ok;
        logic [15:0] field_value;
        logic [7:0]  field_length;
        logic [7:0]  field_start;
        logic        field_done;
    } result_t;

endpackage

@@ src/dft_char_class.sv @@
// Character classifier: separator, quote and space matches and hex digit
// decode for one character. Depends on dft_pkg.
`timescale 1ns / 1ps

module dft_char_class
    import dft_pkg::*;
(
    input  logic [7:0]  ch,
    input  logic [7:0]  separator,
    output char_class_t cls
);

    logic is_dec;
    logic is_upper;
    logic is_lower;

    // Digit ranges
    assign is_dec   = (ch >= CH_0)  && (ch <= CH_9);
    assign is_upper = (ch >= CH_UA) && (ch <= CH_UF);
    assign is_lower = (ch >= CH_LA) && (ch <= CH_LF);

    always_comb begin
        cls.is_sep   = (ch == separator);
        cls.is_quote = (ch == CH_QUOTE);
        cls.is_space = (ch == CH_SPACE);
        cls.is_hex   = is_dec || is_upper || is_lower;
        if (is_dec) begin
            cls.digit = 4'(ch - CH_0);
        end else if (is_upper) begin
            cls.digit = 4'(ch - CH_UA + 8'd10);
        end else if (is_lower) begin
            cls.digit = 4'(ch - CH_LA + 8'd10);
        end else begin
            cls.digit = 4'd0;
        end
    end

endmodule

@@ src/dft_line_fsm.sv @@
// Line state machine: parse state, character index, field start, value
// accumulator and bad digit flag, plus the result for the current character.
// Depends on dft_pkg.
`timescale 1ns / 1ps

module dft_line_fsm
    import dft_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  logic        last,
    input  char_class_t cls,
    input  logic [4:0]  number_base,
    input  logic        allow_empty,
    output result_t     res
);

    localparam int IDX_W = $clog2(MAX_LINE + 1);
    localparam int EXT_W = (IDX_W > 8) ? IDX_W : 8;
    localparam logic [IDX_W-1:0] LINE_LIMIT = IDX_W'(MAX_LINE);

    typedef enum logic [2:0] {
        ST_INIT   = 3'd0,
        ST_EXPR   = 3'd1,
        ST_DELIM  = 3'd2,
        ST_SQUOTE = 3'd3,
        ST_QUOTED = 3'd4,
        ST_EQUOTE = 3'd5,
        ST_END    = 3'd6,
        ST_ERR    = 3'd7
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] begin_reg, begin_next;
    logic [15:0]      acc_reg, acc_next;
    logic             bad_reg, bad_next;

    state_t           cur;
    logic             clear_acc;
    logic [15:0]      acc_base;
    logic [20:0]      prod;
    logic             char_done;
    logic             end_done;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] len;
    logic             ok;

    // Transition for one character out of the registered state
    always_comb begin
        case (state_reg)
            ST_DELIM: begin
                if (cls.is_sep)        cur = ST_DELIM;
                else if (cls.is_quote) cur = ST_SQUOTE;
                else if (cls.is_space) cur = ST_INIT;
                else                   cur = ST_EXPR;
            end
            ST_INIT: begin
                if (cls.is_space)      cur = ST_INIT;
                else if (cls.is_sep)   cur = ST_DELIM;
                else if (cls.is_quote) cur = ST_SQUOTE;
                else                   cur = ST_EXPR;
            end
            ST_QUOTED, ST_SQUOTE: begin
                cur = cls.is_quote ? ST_EQUOTE : ST_QUOTED;
            end
            ST_EXPR: begin
                cur = cls.is_sep ? ST_DELIM : ST_EXPR;
            end
            ST_EQUOTE: begin
                cur = (cls.is_sep || cls.is_space) ? ST_DELIM : ST_ERR;
            end
            default: begin
                cur = ST_ERR;
            end
        endcase
    end

    // A new field clears the accumulator before this character's digit
    assign clear_acc = ((cur == ST_EXPR) && (state_reg != ST_EXPR)) || (cur == ST_SQUOTE);
    assign acc_base  = clear_acc ? 16'd0 : acc_reg;
    assign prod      = 21'(acc_base) * 21'(number_base);

    // Per-character update and field completion
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        begin_next = begin_reg;
        acc_next   = acc_reg;
        bad_next   = bad_reg;
        char_done  = 1'b0;

        if (state_reg != ST_ERR) begin
            if (idx_reg >= LINE_LIMIT) begin
                state_next = ST_ERR;
            end else begin
                if (cur == ST_EXPR && state_reg != ST_EXPR) begin
                    begin_next = idx_reg;
                end else if (cur == ST_SQUOTE) begin
                    begin_next = idx_reg + 1'b1;
                end
                if (clear_acc) begin
                    acc_next = 16'd0;
                    bad_next = 1'b0;
                end
                if (cur == ST_EXPR || cur == ST_QUOTED) begin
                    if (cls.is_hex) begin
                        acc_next = prod[15:0] + 16'(cls.digit);
                    end else begin
                        bad_next = 1'b1;
                    end
                end
                // Empty field between separators, or at a line start or after spaces
                if ((state_reg == ST_DELIM && cur == ST_DELIM) ||
                    (state_reg == ST_INIT && cur == ST_DELIM)) begin
                    begin_next = idx_reg;
                    char_done  = 1'b1;
                end else if (state_reg != cur && cur != ST_EXPR && cur != ST_SQUOTE &&
                             (state_reg == ST_EXPR || cur == ST_EQUOTE)) begin
                    char_done = 1'b1;
                end
                state_next = cur;
                idx_next   = idx_reg + 1'b1;
            end
        end

        // Line end closes an unquoted field still open
        end_done = last && !char_done && (state_next == ST_EXPR);
        if (last && state_next != ST_ERR) begin
            state_next = ST_END;
        end
    end

    // Field report
    assign pos = char_done ? idx_reg : idx_next;
    assign len = (pos >= begin_next) ? (pos - begin_next) : '0;
    assign ok  = (len == '0) ? allow_empty : !bad_next;

    always_comb begin
        res             = '0;
        res.line_end    = last;
        res.parse_error = (state_next == ST_ERR);
        if (char_done || end_done) begin
            res.field_done   = 1'b1;
            res.field_start  = 8'(EXT_W'(begin_next));
            res.field_length = 8'(EXT_W'(len));
            res.value_ok     = ok;
            res.field_value  = (ok && len != '0) ? acc_next : 16'd0;
        end
    end

    // Line state; a last character returns it to the start of a line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            idx_reg   <= '0;
            begin_reg <= '0;
            acc_reg   <= 16'd0;
            bad_reg   <= 1'b0;
        end else if (advance) begin
            if (last) begin
                state_reg <= ST_INIT;
                idx_reg   <= '0;
                begin_reg <= '0;
                acc_reg   <= 16'd0;
                bad_reg   <= 1'b0;
            end else begin
                state_reg <= state_next;
                idx_reg   <= idx_next;
                begin_reg <= begin_next;
                acc_reg   <= acc_next;
                bad_reg   <= bad_next;
            end
        end
    end

endmodule

@@ src/delimited_field_tokenizer.sv @@
// Top level of the delimited field tokenizer: configuration registers,
// classifier, line state machine and output register.
// Depends on dft_pkg, dft_char_class and dft_line_fsm.
//
//   channel   | ports              | moves
//   ----------+--------------------+-------------------------------------------
//   input     | s_tvalid/s_tready  | one character, tlast marks line end
//   result    | m_tvalid/m_tready  | one result per character
//   config    | cfg_we             | separator, number base, allow empty
//
// For each character, the state update and the 16x5 multiply-add
// sit between the line state registers and the output register.
// One result leaves for every character; a new character is taken every cycle
// while the output register is empty or being drained in the same cycle.
// Reset (aresetn low, synchronous) returns the line state and registers to
// their defaults and empties the output register.
`timescale 1ns / 1ps

module delimited_field_tokenizer
    import dft_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    // Character stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // last
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] field_start, [15:8] field_length,
                                   // [31:16] field_value
    output logic [2:0]  m_tuser,   // [0] field_done, [1] value_ok, [2] parse_error
    output logic        m_tlast    // line_end
);

    logic [7:0]  separator_reg;
    logic [4:0]  number_base_reg;
    logic        allow_empty_reg;
    logic        m_tvalid_reg;
    result_t     out_reg;

    logic        s_accept;
    char_class_t cls;
    result_t     res;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            separator_reg   <= SEPARATOR_RST;
            number_base_reg <= NUMBER_BASE_RST;
            allow_empty_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_SEPARATOR:   separator_reg   <= cfg_wdata;
                REG_NUMBER_BASE: number_base_reg <= cfg_wdata[4:0];
                REG_ALLOW_EMPTY: allow_empty_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    dft_char_class u_class (
        .ch        (s_tdata),
        .separator (separator_reg),
        .cls       (cls)
    );

    dft_line_fsm #(
        .MAX_LINE (MAX_LINE)
    ) u_fsm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (s_accept),
        .last        (s_tlast),
        .cls         (cls),
        .number_base (number_base_reg),
        .allow_empty (allow_empty_reg),
        .res         (res)
    );

    // Output register: valid flag under reset, payload loads on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg.field_value, out_reg.field_length, out_reg.field_start};
    assign m_tuser  = {out_reg.parse_error, out_reg.value_ok, out_reg.field_done};
    assign m_tlast  = out_reg.line_end;

`ifndef SYNTHESIS
    // A taken character always shows up as a result in the next cycle
    a_accept_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid)
        else $error("accepted character produced no result");

    // A stalled result is never dropped
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("stalled result lost");

    // Without a completed field, field data and value flag are zero
    a_idle_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 32'd0 && !m_tuser[1]))
        else $error("field data present without a completed field");

    // The error state never completes a field
    a_error_no_field: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[2]))
        else $error("field completed in error state");
`endif

endmodule
